FILE: rtl/ckto_pkg.sv
package ckto_pkg;

  localparam int TEXEL_W = 8;

  typedef logic [TEXEL_W-1:0] texel_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_MERGE = 1'b1;

  localparam int  CFG_ADDR_W = 1;
  localparam int  CFG_DATA_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIENTATION       = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUPER_TRANSPARENT = 1'b1;

  typedef logic [1:0] rot_t;
  localparam rot_t ROT_0   = 2'd0;
  localparam rot_t ROT_90  = 2'd1;
  localparam rot_t ROT_180 = 2'd2;
  localparam rot_t ROT_270 = 2'd3;

  localparam texel_t TEXEL_CLEAR = 8'd255;
  localparam texel_t TEXEL_SUPER = 8'd254;

endpackage

FILE: rtl/ckto_store.sv
module ckto_store #(
  parameter int AW    = 12,
  parameter int DEPTH = 4096
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ckto_pkg::texel_t  wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output ckto_pkg::texel_t  rd_data
);

  ckto_pkg::texel_t mem [DEPTH];
  ckto_pkg::texel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/ckto_addr.sv
module ckto_addr #(
  parameter int SIDE = 64,
  parameter int AW   = 12,
  parameter int CW   = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_fire,
  input  logic           merge_fire,
  input  ckto_pkg::rot_t orientation,
  output logic [AW-1:0]  wr_addr,
  output logic [AW-1:0]  rd_addr,
  output logic           rd_last
);

  localparam logic [CW-1:0] M_C    = CW'(SIDE - 1);
  localparam logic [AW-1:0] SIDE_A = AW'(SIDE);
  localparam logic [AW-1:0] LAST_A = AW'(SIDE * SIDE - 1);

  logic [AW-1:0] load_pos_r, load_pos_nxt;
  logic [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [CW-1:0] row, col;

  // raster counters, each wraps on its own
  always_comb begin
    load_pos_nxt = load_pos_r;
    if (load_fire) begin
      load_pos_nxt = (load_pos_r == LAST_A) ? '0 : load_pos_r + AW'(1);
    end
    x_nxt = x_r;
    y_nxt = y_r;
    if (merge_fire) begin
      if (x_r == M_C) begin
        x_nxt = '0;
        y_nxt = (y_r == M_C) ? '0 : y_r + CW'(1);
      end else begin
        x_nxt = x_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      x_r        <= '0;
      y_r        <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
    end
  end

  // source row and column of the rotated top texel
  always_comb begin
    case (orientation)
      ckto_pkg::ROT_90: begin
        row = x_r;
        col = M_C - y_r;
      end
      ckto_pkg::ROT_180: begin
        row = M_C - y_r;
        col = M_C - x_r;
      end
      ckto_pkg::ROT_270: begin
        row = M_C - x_r;
        col = y_r;
      end
      default: begin
        row = y_r;
        col = x_r;
      end
    endcase
  end

  assign rd_addr = AW'(AW'(row) * SIDE_A + AW'(col));
  assign wr_addr = load_pos_r;
  assign rd_last = (x_r == M_C) && (y_r == M_C);

endmodule

FILE: rtl/color_key_texture_overlay_rotate_top.sv
// Color-key overlay of a SIDE x SIDE paletted top texture onto a bottom texture, with the
// top texture turned by 0..3 quarter turns. A transfer with in_tuser = 0 loads the next top
// texel in raster order into an on-chip store; a transfer with in_tuser = 1 carries the next
// bottom texel and yields one merged texel on the output, tlast on the final texel of the
// texture. Top value 255 shows the bottom texel; with super_transparent set, 254 becomes 255.
// Load and merge positions wrap independently after SIDE*SIDE texels. The block takes one
// transfer per cycle while the output keeps up. A merged texel is formed in the read stage,
// which holds the registered store read, and then passes to the output register; a held
// output can keep it in the read stage. With the read stage and the output register both
// full and the output held, the input stalls, loads included. Configuration
// takes effect from the next merge; write it only while no merged texel is in flight.
module color_key_texture_overlay_rotate_top #(
  parameter int SIDE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // texel
  input  logic                                in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // merged_texel
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [ckto_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ckto_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AREA = SIDE * SIDE;
  localparam int AW   = $clog2(AREA);
  localparam int CW   = $clog2(SIDE);

  ckto_pkg::rot_t   orientation_r;
  logic             super_transparent_r;

  logic             in_fire, load_fire, merge_fire;
  logic             out_adv, s1_move;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             rd_last;
  ckto_pkg::texel_t rd_data;

  logic             s1_valid_r, s1_valid_nxt;
  ckto_pkg::texel_t s1_bottom_r;
  logic             s1_last_r;

  logic             out_valid_r, out_valid_nxt;
  ckto_pkg::texel_t out_data_r, merged;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orientation_r       <= ckto_pkg::ROT_0;
      super_transparent_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        ckto_pkg::CFG_ORIENTATION:       orientation_r       <= cfg_wdata[1:0];
        ckto_pkg::CFG_SUPER_TRANSPARENT: super_transparent_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_valid_r || out_tready;
  assign s1_move    = s1_valid_r && out_adv;
  assign in_tready  = !s1_valid_r || out_adv;
  assign in_fire    = in_tvalid && in_tready;
  assign load_fire  = in_fire && (in_tuser == ckto_pkg::KIND_LOAD);
  assign merge_fire = in_fire && (in_tuser == ckto_pkg::KIND_MERGE);

  ckto_addr #(
    .SIDE (SIDE),
    .AW   (AW),
    .CW   (CW)
  ) u_addr (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_fire   (load_fire),
    .merge_fire  (merge_fire),
    .orientation (orientation_r),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .rd_last     (rd_last)
  );

  ckto_store #(
    .AW    (AW),
    .DEPTH (AREA)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (merge_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // color key on the fetched top texel
  always_comb begin
    merged = rd_data;
    if (rd_data == ckto_pkg::TEXEL_CLEAR) begin
      merged = s1_bottom_r;
    end else if (super_transparent_r && (rd_data == ckto_pkg::TEXEL_SUPER)) begin
      merged = ckto_pkg::TEXEL_CLEAR;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (merge_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_fire) begin
      s1_bottom_r <= in_tdata;
      s1_last_r   <= rd_last;
    end
    if (s1_move) begin
      out_data_r <= merged;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |-> !merge_fire)
    else $error("merge transfer while read stage is stalled");

  a_merge_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    merge_fire |=> s1_valid_r)
    else $error("merge transfer lost before read stage");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("read stage result lost before output");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (load_fire && !s1_valid_r) |=> !s1_valid_r)
    else $error("load transfer created a result");
`endif

endmodule

FILE: dv/tb_color_key_texture_overlay_rotate_top.sv
`timescale 1ns / 1ps

module tb_color_key_texture_overlay_rotate_top;

  localparam int SIDE = 64;
  localparam int AREA = SIDE * SIDE;
  localparam int POS_W = $clog2(AREA);
  localparam int HALF = POS_W / 2;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic             kind;
    ckto_pkg::texel_t texel;
  } texel_xfer_t;

  typedef struct packed {
    ckto_pkg::texel_t texel;
    logic             last;
  } merged_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [7:0]                      out_tdata;
  logic                            out_tlast;
  logic                            cfg_wr_en;
  logic [ckto_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [ckto_pkg::CFG_DATA_W-1:0] cfg_wdata;

  color_key_texture_overlay_rotate_top #(.SIDE(SIDE)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // overlay predictor state
  ckto_pkg::texel_t top_mem [AREA];
  pos_t             load_pos = '0;
  pos_t             merge_pos = '0;
  ckto_pkg::rot_t   cur_rot = ckto_pkg::ROT_0;
  logic             cur_super = 1'b0;

  // stimulus planning shadow
  pos_t           plan_load_pos = '0;
  pos_t           plan_merge_pos = '0;
  ckto_pkg::rot_t plan_rot = ckto_pkg::ROT_0;
  bit [AREA-1:0]  plan_written = '0;

  texel_xfer_t pend_q[$];
  merged_t     merged_q[$];

  int          fail_count = 0;
  int          loads_seen = 0;
  int          merges_seen = 0;
  int          in_gap = 0;
  int          in_sent = 0;
  texel_xfer_t in_next;
  int          out_stall = 0;
  int          out_taken = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic        ready_nxt;
  int          idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic pos_t rot_index(pos_t pos, ckto_pkg::rot_t r);
    logic [HALF-1:0] y;
    logic [HALF-1:0] x;
    y = pos[POS_W-1:HALF];
    x = pos[HALF-1:0];
    case (r)
      ckto_pkg::ROT_90:  return {x, ~y};
      ckto_pkg::ROT_180: return {~y, ~x};
      ckto_pkg::ROT_270: return {~x, y};
      default:           return pos;
    endcase
  endfunction

  function automatic void load_top(ckto_pkg::texel_t tx);
    top_mem[load_pos] = tx;
    load_pos++;
  endfunction

  function automatic merged_t merge_texel(ckto_pkg::texel_t bottom);
    merged_t          r;
    ckto_pkg::texel_t top;
    top = top_mem[rot_index(merge_pos, cur_rot)];
    if (top == ckto_pkg::TEXEL_CLEAR) r.texel = bottom;
    else if (cur_super && top == ckto_pkg::TEXEL_SUPER) r.texel = ckto_pkg::TEXEL_CLEAR;
    else r.texel = top;
    r.last = (merge_pos == pos_t'(AREA - 1));
    merge_pos++;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and calm windows with none
  function automatic int pick_gap(int n);
    int r;
    r = $urandom_range(0, 99);
    if ((n / 200) % 3 == 2) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic ckto_pkg::texel_t pick_top();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return ckto_pkg::TEXEL_CLEAR;
    if (r == 3) return ckto_pkg::TEXEL_SUPER;
    return ckto_pkg::texel_t'($urandom_range(0, 255));
  endfunction

  function automatic ckto_pkg::texel_t pick_bottom();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return ckto_pkg::texel_t'($urandom_range(0, 255));
  endfunction

  task automatic push_load(ckto_pkg::texel_t tx);
    pend_q.push_back('{ckto_pkg::KIND_LOAD, tx});
    plan_written[plan_load_pos] = 1'b1;
    plan_load_pos++;
  endtask

  task automatic push_merge(ckto_pkg::texel_t tx);
    pend_q.push_back('{ckto_pkg::KIND_MERGE, tx});
    plan_merge_pos++;
  endtask

  // merges only where the rotated store entry has been loaded
  task automatic plan_one(int load_pct);
    if ($urandom_range(0, 99) < load_pct ||
        !plan_written[rot_index(plan_merge_pos, plan_rot)]) begin
      push_load(pick_top());
    end else begin
      push_merge(pick_bottom());
    end
  endtask

  task automatic plan_items(int n, int load_pct);
    for (int i = 0; i < n; i++) plan_one(load_pct);
  endtask

  // sampled between edges so that pops and drives of the same edge have settled
  task automatic drain();
    @(negedge clk);
    while (pend_q.size() != 0 || in_tvalid || merged_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ckto_pkg::CFG_ADDR_W-1:0] addr,
                           logic [ckto_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_mode(ckto_pkg::rot_t r, logic sup);
    drain();
    cfg_write(ckto_pkg::CFG_ORIENTATION, ckto_pkg::CFG_DATA_W'(r));
    cfg_write(ckto_pkg::CFG_SUPER_TRANSPARENT, ckto_pkg::CFG_DATA_W'(sup));
    cur_rot = r;
    cur_super = sup;
    plan_rot = r;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // quarter turn from reset, each merge as soon as its turned entry is loaded
    set_mode(ckto_pkg::ROT_90, 1'b1);
    plan_items(300, 0);

    // no rotation, plain color key, loads and merges interleaved
    set_mode(ckto_pkg::ROT_0, 1'b0);
    plan_items(500, 50);

    // no rotation with super-transparent on
    set_mode(ckto_pkg::ROT_0, 1'b1);
    plan_items(600, 45);

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d top loads and %0d merges", loads_seen, merges_seen);
    $display("quarter turn and no rotation, super-transparent on and off, long output hold");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_next = pend_q.pop_front();
        in_tuser <= in_next.kind;
        in_tdata <= in_next.texel;
        in_tvalid <= 1'b1;
        in_sent++;
        in_gap = pick_gap(in_sent);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_taken++;
      if (!hold_done && out_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
        if (out_tvalid && out_tready) out_stall = pick_gap(out_taken);
      end
      out_tready <= ready_nxt;
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == ckto_pkg::KIND_MERGE) begin
          merged_q.push_back(merge_texel(in_tdata));
          merges_seen++;
        end else begin
          load_top(in_tdata);
          loads_seen++;
        end
      end
      if (out_tvalid && out_tready) begin
        if (merged_q.size() == 0) begin
          $error("unexpected merged texel %0d last %0d", out_tdata, out_tlast);
          fail_count++;
        end else begin
          if (merged_q[0].texel != out_tdata) begin
            $error("merged_texel: expected %0d, got %0d", merged_q[0].texel, out_tdata);
            fail_count++;
          end
          if (merged_q[0].last != out_tlast) begin
            $error("last_texel: expected %0d, got %0d", merged_q[0].last, out_tlast);
            fail_count++;
          end
          void'(merged_q.pop_front());
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
